[design/aca_pkg.sv]
// shared constants, codes and helpers for the all-pattern matcher
// no dependencies
package aca_pkg;

  localparam int DEF_MAX_STATES   = 256;
  localparam int DEF_MAX_PATTERNS = 16;
  localparam int FIRST_CHAR       = 32;
  localparam int COLS             = 128 - FIRST_CHAR;
  localparam int COL_W            = 7;
  localparam int LEN_W            = 10;
  localparam int CMD_W            = 2;

  localparam logic [COL_W-1:0] LAST_COL     = COL_W'(COLS - 1);
  localparam logic [LEN_W-1:0] NAME_LEN_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_NAME  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_CASE    = 1'b0,
    REG_MIN_LEN = 1'b1
  } reg_idx_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_BUILD   = 1'b1
  } kind_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic case_sens);
    if (!case_sens && b >= 8'h41 && b <= 8'h5a) begin
      return b + 8'd32;
    end
    return b;
  endfunction

endpackage

[design/aho_corasick_all_pattern_matcher_core.sv]
// Name byte: transition then pattern-end memory (ST_SC_T, ST_SC_M) unless skipped or
// a control byte; pattern char: ST_LD_T if printable, ST_LD_M if last; result register
// loads in ST_OUT once free. Build: ST_BR_RD, ST_BR_EV per root column, then per queued
// state ST_BP_POP, ST_BP_S, ST_BP_F, per column ST_BL_RD, ST_BL_EV, ST_BL_M if child.
// Clear and reset: a clearing pass over the transition and pattern-end memories, with
// no item accepted until it ends; control registers reset synchronously.
// Depends on aca_pkg and aca_ram.
module aho_corasick_all_pattern_matcher_core #(
  parameter int MAX_STATES   = aca_pkg::DEF_MAX_STATES,
  parameter int MAX_PATTERNS = aca_pkg::DEF_MAX_PATTERNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] cmd
  input  logic       in_tlast,   // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] matched, [1] too_short, [2] table_full, rest zero
  output logic       out_tuser,  // [0] kind
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [9:0] cfg_wdata
);
  import aca_pkg::*;

  localparam int SW  = $clog2(MAX_STATES);
  localparam int GW  = SW + 1;
  localparam int GD  = MAX_STATES * COLS;
  localparam int GAW = $clog2(GD);
  localparam int PW  = MAX_PATTERNS;
  localparam int PCW = $clog2(MAX_PATTERNS + 1);

  localparam logic [GW-1:0] ABSENT = {1'b1, {SW{1'b0}}};

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_LD_T, ST_LD_M, ST_SC_T, ST_SC_M, ST_BR_RD, ST_BR_EV,
    ST_BP_POP, ST_BP_S, ST_BP_F, ST_BL_RD, ST_BL_EV, ST_BL_M, ST_OUT
  } state_t;

  function automatic logic [GAW-1:0] goto_addr(input logic [SW-1:0] s,
                                               input logic [COL_W-1:0] c);
    return GAW'(s) * GAW'(COLS) + GAW'(c);
  endfunction

  // configuration
  logic             case_sens_r;
  logic [LEN_W-1:0] min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sens_r <= 1'b1;
      min_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CASE:    case_sens_r <= cfg_wdata[0];
        REG_MIN_LEN: min_len_r   <= cfg_wdata;
        default:     min_len_r   <= min_len_r;
      endcase
    end
  end

  // memory ports
  logic           g_we;
  logic [GAW-1:0] g_wa, ga_ra, gb_ra;
  logic [GW-1:0]  g_wd, ga_rd, gb_rd;
  logic           e_we;
  logic [SW-1:0]  e_wa, ea_ra, eb_ra;
  logic [PW-1:0]  e_wd, ea_rd, eb_rd;
  logic           f_we, q_we;
  logic [SW-1:0]  f_wa, f_wd, f_ra, f_rd, q_wa, q_wd, q_ra, q_rd;

  // transition table and pattern ends are duplicated for a second read port
  aca_ram #(.WIDTH(GW), .DEPTH(GD)) u_goto_a (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(ga_ra), .rdata(ga_rd));
  aca_ram #(.WIDTH(GW), .DEPTH(GD)) u_goto_b (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(gb_ra), .rdata(gb_rd));
  aca_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_end_a (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(ea_ra), .rdata(ea_rd));
  aca_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_end_b (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(eb_ra), .rdata(eb_rd));
  aca_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_fail (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  aca_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // control state
  state_t           state_r, state_nxt;
  logic [GAW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]    used_r, used_nxt, cursor_r, cursor_nxt, scan_r, scan_nxt;
  logic [PCW-1:0]   npat_r, npat_nxt;
  logic [PW-1:0]    seen_r, seen_nxt, root_mask_r, root_mask_nxt;
  logic [LEN_W-1:0] nlen_r, nlen_nxt;
  logic [1:0]       skip_r, skip_nxt;
  logic             ovf_r, ovf_nxt, built_r, built_nxt;
  logic [SW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [COL_W-1:0] c_r, c_nxt;
  logic             out_valid_r, out_valid_nxt;
  // payload
  logic [COL_W-1:0] col_r, col_nxt;
  logic             last_r, last_nxt;
  logic [SW-1:0]    s_r, s_nxt, f_r, f_nxt, t_r, t_nxt;
  kind_t            res_kind_r, res_kind_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic             out_match_r, out_match_nxt, out_short_r, out_short_nxt;
  logic             out_full_r, out_full_nxt;

  logic [7:0]       fb;
  logic [COL_W-1:0] col_in;
  logic             slot_free;
  logic [PW-1:0]    pbit, need, have;
  logic             short_name, hit;
  logic [SW-1:0]    cur_new, t_val;

  assign fb        = fold_byte(in_tdata, case_sens_r);
  assign col_in    = COL_W'(fb - 8'(FIRST_CHAR));
  assign slot_free = !out_valid_r || out_tready;
  assign pbit      = PW'(1) << npat_r;
  assign have      = seen_r | root_mask_r;
  assign short_name = nlen_r < min_len_r;
  assign hit       = !short_name && !ovf_r && ((have & need) == need);

  always_comb begin
    for (int i = 0; i < PW; i++) begin
      need[i] = PCW'(i) < npat_r;
    end
  end

  always_comb begin
    state_nxt = state_r;       clr_cnt_nxt = clr_cnt_r;  used_nxt = used_r;
    cursor_nxt = cursor_r;     scan_nxt = scan_r;        npat_nxt = npat_r;
    seen_nxt = seen_r;         root_mask_nxt = root_mask_r;
    nlen_nxt = nlen_r;         skip_nxt = skip_r;        ovf_nxt = ovf_r;
    built_nxt = built_r;       head_nxt = head_r;        tail_nxt = tail_r;
    c_nxt = c_r;               col_nxt = col_r;          last_nxt = last_r;
    s_nxt = s_r;               f_nxt = f_r;              t_nxt = t_r;
    res_kind_nxt = res_kind_r; out_kind_nxt = out_kind_r;
    out_match_nxt = out_match_r; out_short_nxt = out_short_r; out_full_nxt = out_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready = 1'b0;
    g_we = 1'b0; g_wa = '0; g_wd = '0; ga_ra = '0; gb_ra = '0;
    e_we = 1'b0; e_wa = '0; e_wd = '0; ea_ra = '0; eb_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    cur_new = cursor_r;
    t_val = ga_rd[SW-1:0];

    unique case (state_r)
      ST_CLR: begin
        g_we = 1'b1;
        g_wa = clr_cnt_r;
        g_wd = ABSENT;
        if (clr_cnt_r < GAW'(MAX_STATES)) begin
          e_we = 1'b1;
          e_wa = clr_cnt_r[SW-1:0];
        end
        if (clr_cnt_r == GAW'(GD - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          last_nxt = in_tlast;
          col_nxt  = col_in;
          unique case (cmd_t'(in_tuser))
            CMD_CLEAR: begin
              state_nxt = ST_CLR;   clr_cnt_nxt = '0;
              used_nxt = '0;        cursor_nxt = '0;  scan_nxt = '0;
              npat_nxt = '0;        seen_nxt = '0;    root_mask_nxt = '0;
              nlen_nxt = '0;        skip_nxt = '0;    ovf_nxt = 1'b0;
              built_nxt = 1'b0;
            end
            CMD_CHAR: begin
              if (!built_r) begin
                if (npat_r >= PCW'(MAX_PATTERNS)) begin
                  ovf_nxt = 1'b1;
                end else if (in_tdata >= 8'(FIRST_CHAR) && !in_tdata[7]) begin
                  ga_ra = goto_addr(cursor_r, col_in);
                  state_nxt = ST_LD_T;
                end else if (in_tlast) begin
                  ea_ra = cursor_r;
                  state_nxt = ST_LD_M;
                end
              end
            end
            CMD_BUILD: begin
              scan_nxt = '0; seen_nxt = '0; nlen_nxt = '0; skip_nxt = '0;
              res_kind_nxt = KIND_BUILD;
              if (built_r) begin
                state_nxt = ST_OUT;
              end else begin
                built_nxt = 1'b1;
                c_nxt = '0; head_nxt = '0; tail_nxt = '0;
                state_nxt = ST_BR_RD;
              end
            end
            CMD_NAME: begin
              res_kind_nxt = KIND_VERDICT;
              if (nlen_r != NAME_LEN_MAX) begin
                nlen_nxt = nlen_r + 1'b1;
              end
              if (skip_r != 2'd0) begin
                skip_nxt = skip_r - 1'b1;
                if (in_tlast) state_nxt = ST_OUT;
              end else if (in_tdata[7]) begin
                scan_nxt = '0;
                skip_nxt = 2'd2;
                if (in_tlast) state_nxt = ST_OUT;
              end else if (in_tdata < 8'(FIRST_CHAR)) begin
                scan_nxt = '0;
                if (in_tlast) state_nxt = ST_OUT;
              end else begin
                ga_ra = goto_addr(scan_r, col_in);
                state_nxt = ST_SC_T;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_LD_T: begin
        if (ga_rd[SW]) begin
          if (used_r != SW'(MAX_STATES - 1)) begin
            cur_new = used_r + 1'b1;
            used_nxt = cur_new;
            g_we = 1'b1;
            g_wa = goto_addr(cursor_r, col_r);
            g_wd = {1'b0, cur_new};
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          cur_new = t_val;
        end
        cursor_nxt = cur_new;
        if (last_r) begin
          ea_ra = cur_new;
          state_nxt = ST_LD_M;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_LD_M: begin
        e_we = 1'b1;
        e_wa = cursor_r;
        e_wd = ea_rd | pbit;
        if (cursor_r == '0) root_mask_nxt = root_mask_r | pbit;
        npat_nxt = npat_r + 1'b1;
        cursor_nxt = '0;
        state_nxt = ST_IDLE;
      end

      ST_SC_T: begin
        cur_new = ga_rd[SW] ? '0 : t_val;
        scan_nxt = cur_new;
        ea_ra = cur_new;
        state_nxt = ST_SC_M;
      end

      ST_SC_M: begin
        seen_nxt = seen_r | ea_rd;
        state_nxt = last_r ? ST_OUT : ST_IDLE;
      end

      // root row: missing edges loop to the root, children get the root as fail
      ST_BR_RD: begin
        ga_ra = goto_addr('0, c_r);
        state_nxt = ST_BR_EV;
      end

      ST_BR_EV: begin
        if (ga_rd[SW]) begin
          g_we = 1'b1;
          g_wa = goto_addr('0, c_r);
          g_wd = '0;
        end else begin
          f_we = 1'b1; f_wa = t_val; f_wd = '0;
          q_we = 1'b1; q_wa = tail_r; q_wd = t_val;
          tail_nxt = tail_r + 1'b1;
        end
        if (c_r == LAST_COL) begin
          state_nxt = (tail_nxt == head_r) ? ST_OUT : ST_BP_POP;
        end else begin
          c_nxt = c_r + 1'b1;
          state_nxt = ST_BR_RD;
        end
      end

      ST_BP_POP: begin
        q_ra = head_r;
        state_nxt = ST_BP_S;
      end

      ST_BP_S: begin
        s_nxt = q_rd;
        head_nxt = head_r + 1'b1;
        f_ra = q_rd;
        state_nxt = ST_BP_F;
      end

      ST_BP_F: begin
        f_nxt = f_rd;
        c_nxt = '0;
        state_nxt = ST_BL_RD;
      end

      ST_BL_RD: begin
        ga_ra = goto_addr(s_r, c_r);
        gb_ra = goto_addr(f_r, c_r);
        state_nxt = ST_BL_EV;
      end

      ST_BL_EV: begin
        if (ga_rd[SW]) begin
          // the fail row is already complete, so copy its edge
          g_we = 1'b1;
          g_wa = goto_addr(s_r, c_r);
          g_wd = gb_rd;
          if (c_r == LAST_COL) begin
            state_nxt = (tail_r == head_r) ? ST_OUT : ST_BP_POP;
          end else begin
            c_nxt = c_r + 1'b1;
            state_nxt = ST_BL_RD;
          end
        end else begin
          f_we = 1'b1; f_wa = t_val; f_wd = gb_rd[SW-1:0];
          q_we = 1'b1; q_wa = tail_r; q_wd = t_val;
          tail_nxt = tail_r + 1'b1;
          ea_ra = t_val;
          eb_ra = gb_rd[SW-1:0];
          t_nxt = t_val;
          state_nxt = ST_BL_M;
        end
      end

      ST_BL_M: begin
        // child inherits the pattern ends of its fail target
        e_we = 1'b1;
        e_wa = t_r;
        e_wd = ea_rd | eb_rd;
        if (c_r == LAST_COL) begin
          state_nxt = (tail_r == head_r) ? ST_OUT : ST_BP_POP;
        end else begin
          c_nxt = c_r + 1'b1;
          state_nxt = ST_BL_RD;
        end
      end

      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_full_nxt  = ovf_r;
          if (res_kind_r == KIND_VERDICT) begin
            out_match_nxt = hit;
            out_short_nxt = short_name;
            scan_nxt = '0; seen_nxt = '0; nlen_nxt = '0; skip_nxt = '0;
          end else begin
            out_match_nxt = 1'b0;
            out_short_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;   clr_cnt_r <= '0;    used_r <= '0;
      cursor_r <= '0;      scan_r <= '0;       npat_r <= '0;
      seen_r <= '0;        root_mask_r <= '0;  nlen_r <= '0;
      skip_r <= '0;        ovf_r <= 1'b0;      built_r <= 1'b0;
      head_r <= '0;        tail_r <= '0;       c_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;   clr_cnt_r <= clr_cnt_nxt;  used_r <= used_nxt;
      cursor_r <= cursor_nxt; scan_r <= scan_nxt;        npat_r <= npat_nxt;
      seen_r <= seen_nxt;     root_mask_r <= root_mask_nxt; nlen_r <= nlen_nxt;
      skip_r <= skip_nxt;     ovf_r <= ovf_nxt;          built_r <= built_nxt;
      head_r <= head_nxt;     tail_r <= tail_nxt;        c_r <= c_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r <= col_nxt;         last_r <= last_nxt;
    s_r <= s_nxt;             f_r <= f_nxt;              t_r <= t_nxt;
    res_kind_r <= res_kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_match_r <= out_match_nxt;
    out_short_r <= out_short_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_full_r, out_short_r, out_match_r};

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BP_POP) |-> (head_r != tail_r))
    else $error("queue pop while empty");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_tready)
    else $error("item taken during clearing pass");

  a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_match_r) |-> (!out_full_r && !out_short_r && out_kind_r == KIND_VERDICT))
    else $error("match reported with overflow, short name or build status");

  a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && slot_free && res_kind_r == KIND_VERDICT)
      |=> (seen_r == '0 && nlen_r == '0 && skip_r == 2'd0 && scan_r == '0))
    else $error("scan state kept after a verdict");
`endif

endmodule

[design/aca_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module aca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/aho_corasick_all_pattern_matcher_core_tb.sv]
// testbench for the all-pattern matcher core: directed and random command streams
// checked against an automaton predictor kept in the testbench; needs aca_pkg and the core
`timescale 1ns / 1ps

module aho_corasick_all_pattern_matcher_core_tb;
  import aca_pkg::*;

  localparam int NSTATES   = DEF_MAX_STATES;
  localparam int NPATTERNS = DEF_MAX_PATTERNS;
  localparam int ABSENT    = 32'hFFFF;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    kind_t kind;
    logic  matched;
    logic  too_short;
    logic  table_full;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       cfg_we = 1'b0;
  logic       cfg_addr = 1'b0;
  logic [9:0] cfg_wdata = '0;

  aho_corasick_all_pattern_matcher_core dut (.*);

  always #6 clk = ~clk;

  // automaton predictor state
  int unsigned trans [NSTATES*COLS];
  int unsigned fail_to [NSTATES];
  int unsigned ends [NSTATES];
  int unsigned n_states, n_pats, cursor, scan_st, seen, n_bytes, skip_cnt;
  bit          ovf, is_built;
  bit          case_sens = 1'b1;
  int unsigned min_len = 0;

  verdict_t verdicts [$];
  int       errors = 0;
  bit       idle_on = 1'b1;
  int       hold_req = 0;
  int       busy_cnt = 0;
  int       quiet = 0;

  function automatic int unsigned fold_ch(int unsigned b);
    if (!case_sens && b >= 65 && b <= 90) return b + 32;
    return b;
  endfunction

  function automatic void clear_automaton();
    foreach (trans[i]) trans[i] = ABSENT;
    foreach (fail_to[i]) fail_to[i] = 0;
    foreach (ends[i]) ends[i] = 0;
    n_states = 0; n_pats = 0; cursor = 0; scan_st = 0; seen = 0;
    n_bytes = 0; skip_cnt = 0; ovf = 0; is_built = 0;
  endfunction

  function automatic void add_pattern_char(int unsigned b, bit last);
    int unsigned c, t;
    if (is_built) return;
    if (n_pats >= NPATTERNS) begin
      ovf = 1;
      return;
    end
    if (b >= FIRST_CHAR && b < 128) begin
      c = fold_ch(b) - FIRST_CHAR;
      t = trans[cursor*COLS + c];
      if (t == ABSENT) begin
        if (n_states + 1 < NSTATES) begin
          n_states++;
          trans[cursor*COLS + c] = n_states;
          cursor = n_states;
        end else begin
          ovf = 1;
        end
      end else begin
        cursor = t;
      end
    end
    if (last) begin
      ends[cursor] |= 32'd1 << n_pats;
      n_pats++;
      cursor = 0;
    end
  endfunction

  function automatic void build_links();
    int unsigned bfs [$];
    int unsigned s, f, t, nf;
    scan_st = 0; seen = 0; n_bytes = 0; skip_cnt = 0;
    if (is_built) return;
    is_built = 1;
    for (int c = 0; c < COLS; c++) begin
      t = trans[c];
      if (t == ABSENT) trans[c] = 0;
      else begin
        fail_to[t] = 0;
        bfs = {bfs, t};
      end
    end
    while (bfs.size() > 0) begin
      s = bfs.pop_front();
      f = fail_to[s];
      for (int c = 0; c < COLS; c++) begin
        t = trans[s*COLS + c];
        if (t == ABSENT) trans[s*COLS + c] = trans[f*COLS + c];
        else begin
          nf = trans[f*COLS + c] % NSTATES;
          fail_to[t] = nf;
          ends[t] |= ends[nf];
          bfs = {bfs, t};
        end
      end
    end
  endfunction

  function automatic void predict_verdict(cmd_t cmd, int unsigned b, bit last);
    verdict_t v;
    int unsigned t, need;
    case (cmd)
      CMD_CLEAR: clear_automaton();
      CMD_CHAR:  add_pattern_char(b, last);
      CMD_BUILD: begin
        build_links();
        v = '{KIND_BUILD, 1'b0, 1'b0, ovf};
        verdicts = {verdicts, v};
      end
      default: begin
        if (n_bytes < 1023) n_bytes++;
        if (skip_cnt > 0) skip_cnt--;
        else if (b >= 128) begin
          scan_st = 0;
          skip_cnt = 2;
        end else if (b < FIRST_CHAR) scan_st = 0;
        else begin
          t = trans[scan_st*COLS + fold_ch(b) - FIRST_CHAR];
          scan_st = (t == ABSENT) ? 0 : t % NSTATES;
          seen |= ends[scan_st];
        end
        if (last) begin
          need = (32'd1 << n_pats) - 1;
          v.kind = KIND_VERDICT;
          v.too_short = n_bytes < min_len;
          v.table_full = ovf;
          v.matched = !v.too_short && !ovf && (((seen | ends[0]) & need) == need);
          verdicts = {verdicts, v};
          scan_st = 0; seen = 0; n_bytes = 0; skip_cnt = 0;
        end
      end
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic [7:0] b, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_verdict(cmd, b, last);
  endtask

  task automatic send_str(cmd_t cmd, string s);
    if (s.len() == 0) send_item(cmd, 8'h01, 1'b1);
    for (int i = 0; i < s.len(); i++) send_item(cmd, s[i], i == s.len() - 1);
  endtask

  // sender pause: every pending result delivered, pipeline settled
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdicts.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CASE) case_sens = val[0];
    else min_len = val;
  endtask

  task automatic test_directed();
    send_str(CMD_CHAR, "abc");
    send_str(CMD_CHAR, "Bc");
    send_str(CMD_CHAR, "");
    send_item(CMD_CHAR, 8'h1f, 1'b0);
    send_item(CMD_CHAR, 8'h80, 1'b0);
    send_str(CMD_CHAR, "q");
    send_item(CMD_CHAR, 8'h7e, 1'b0);
    send_item(CMD_CHAR, 8'h7f, 1'b1);
    send_str(CMD_NAME, "abcq");
    send_item(CMD_BUILD, 8'h00, 1'b0);
    send_item(CMD_BUILD, 8'hff, 1'b1);
    send_str(CMD_CHAR, "z");
    send_str(CMD_NAME, "xabcBcq~");
    send_item(CMD_NAME, 8'h7f, 1'b1);
    send_str(CMD_NAME, "Bc");
    send_item(CMD_NAME, 8'hc3, 1'b0);
    send_str(CMD_NAME, "abq");
    send_str(CMD_NAME, "ab");
    send_item(CMD_NAME, 8'h0a, 1'b0);
    send_str(CMD_NAME, "cq");
    send_item(CMD_NAME, 8'hff, 1'b1);
    wait_drained();
    write_reg(REG_MIN_LEN, 10'd5);
    write_reg(REG_CASE, 10'd0);
    send_str(CMD_NAME, "q");
    send_str(CMD_NAME, "ABCBCQ~");
  endtask

  task automatic test_limits();
    string p;
    wait_drained();
    write_reg(REG_MIN_LEN, 10'd0);
    write_reg(REG_CASE, 10'd1);
    send_item(CMD_CLEAR, 8'h00, 1'b0);
    // one pattern beyond the pattern limit
    for (int i = 0; i <= NPATTERNS; i++) send_item(CMD_CHAR, 8'(97 + i), 1'b1);
    send_item(CMD_BUILD, 8'h00, 1'b0);
    send_str(CMD_NAME, "abcdefghijklmnopq");
    // more trie states than the table holds
    send_item(CMD_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < NPATTERNS; i++) begin
      p = "xxxxxxxxxxxxxxx";
      send_item(CMD_CHAR, 8'(33 + i), 1'b0);
      send_str(CMD_CHAR, p);
    end
    send_item(CMD_BUILD, 8'h00, 1'b0);
    send_str(CMD_NAME, "!xxxxxxxxxxxxxxx");
  endtask

  task automatic test_long_name();
    wait_drained();
    write_reg(REG_MIN_LEN, 10'd1023);
    send_item(CMD_CLEAR, 8'h00, 1'b0);
    send_str(CMD_CHAR, "ab");
    send_item(CMD_BUILD, 8'h00, 1'b0);
    send_str(CMD_NAME, "xab");
    // length counter saturates and still meets the longest minimum
    for (int i = 0; i < 1025; i++) send_item(CMD_NAME, (i == 500) ? 8'h61 : 8'h62, i == 1024);
    send_str(CMD_NAME, "ab");
  endtask

  function automatic logic [7:0] rand_letter();
    string abc = "abcAB";
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return abc[$urandom_range(0, 4)];
  endfunction

  task automatic test_random(int rounds, int names_per_round, bit with_hold);
    string pats [$];
    string p, nm;
    int    k;
    for (int r = 0; r < rounds; r++) begin
      wait_drained();
      write_reg(REG_CASE, 10'($urandom_range(0, 1)));
      write_reg(REG_MIN_LEN, ($urandom_range(0, 9) == 0) ? 10'd1023 : 10'($urandom_range(0, 8)));
      send_item(CMD_CLEAR, 8'h00, 1'b0);
      pats.delete();
      k = $urandom_range(0, 5);
      for (int i = 0; i < k; i++) begin
        p = "";
        repeat ($urandom_range(0, 4)) p = {p, string'(rand_letter())};
        pats = {pats, p};
        send_str(CMD_CHAR, p);
      end
      if ($urandom_range(0, 4) != 0) send_item(CMD_BUILD, 8'h00, 1'b0);
      if (with_hold && r == 0) hold_req = 400;
      for (int n = 0; n < names_per_round; n++) begin
        nm = "";
        foreach (pats[i])
          if ($urandom_range(0, 3) != 0) nm = {nm, pats[i]};
        repeat ($urandom_range(0, 4)) nm = {nm, string'(rand_letter())};
        if (nm.len() == 0) nm = "a";
        if (nm.len() > 14) nm = nm.substr(0, 13);
        send_str(CMD_NAME, nm);
        if ($urandom_range(0, 19) == 0)
          send_item(($urandom_range(0, 1) == 0) ? CMD_CHAR : CMD_BUILD,
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      busy_cnt = hold_req;
      hold_req = 0;
    end
    if (busy_cnt > 0) begin
      busy_cnt--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      busy_cnt = $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts.size() == 0) begin
        $error("result with nothing expected: tuser %0d tdata %h", out_tuser, out_tdata);
        errors++;
      end else begin
        want = verdicts.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind expected %0d got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[0] !== want.matched) begin
          $error("matched expected %0d got %0d", want.matched, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want.too_short) begin
          $error("too_short expected %0d got %0d", want.too_short, out_tdata[1]);
          errors++;
        end
        if (out_tdata[2] !== want.table_full) begin
          $error("table_full expected %0d got %0d", want.table_full, out_tdata[2]);
          errors++;
        end
        if (out_tdata[7:3] !== 5'd0) begin
          $error("tdata pad expected 0 got %0d", out_tdata[7:3]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("aho_corasick_all_pattern_matcher_core_tb: errors");
      $finish;
    end
  end

  initial begin
    clear_automaton();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limits();
    test_long_name();
    test_random(2, 6, 1'b1);
    wait_drained();
    idle_on = 1'b0;
    test_random(1, 6, 1'b0);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("aho_corasick_all_pattern_matcher_core_tb: clean");
    else $display("aho_corasick_all_pattern_matcher_core_tb: errors");
    $finish;
  end

endmodule
